### design/assert_macros.svh
// Assertion macros for the design files that carry checks (the top level includes them).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### design/i2cee_pkg.sv
// Package with the types, step codes and constants of the EEPROM access master.
`default_nettype none
package i2cee_pkg;

    localparam int STEP_W     = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [STEP_W-1:0] ST_IDLE   = 4'd0;
    localparam logic [STEP_W-1:0] ST_START1 = 4'd1;
    localparam logic [STEP_W-1:0] ST_DEVW   = 4'd2;
    localparam logic [STEP_W-1:0] ST_WADDR  = 4'd3;
    localparam logic [STEP_W-1:0] ST_WDATA  = 4'd4;
    localparam logic [STEP_W-1:0] ST_START2 = 4'd5;
    localparam logic [STEP_W-1:0] ST_DEVR   = 4'd6;
    localparam logic [STEP_W-1:0] ST_RDATA  = 4'd7;
    localparam logic [STEP_W-1:0] ST_STOP   = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS    = 1'd1;

    localparam logic [6:0]  DEVICE_ADDRESS_RST = 7'd80;
    localparam logic [15:0] PHASE_TICKS_RST    = 16'd5;

    // Read/write bit appended to the device address.
    localparam logic RW_WRITE = 1'b0;
    localparam logic RW_READ  = 1'b1;

    // Operation codes of a request.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic       start_request;
        logic       operation;
        logic [7:0] word_address;
        logic [7:0] write_data;
        logic       sda_in;
    } t_req;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
    } t_res;

endpackage
`default_nettype wire

### design/i2cee_req_if.sv
// Request channel interface: one bus tick with its request fields.
`default_nettype none
interface i2cee_req_if;
    logic       valid;
    logic       ready;
    logic       start_request;
    logic       operation;
    logic [7:0] word_address;
    logic [7:0] write_data;
    logic       sda_in;

    modport source (output valid, start_request, operation, word_address, write_data,
                    sda_in, input ready);
    modport sink (input valid, start_request, operation, word_address, write_data,
                  sda_in, output ready);
endinterface
`default_nettype wire

### design/i2cee_res_if.sv
// Result channel interface: bus levels and status for one tick.
`default_nettype none
interface i2cee_res_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;

    modport source (output valid, scl_level, sda_level, busy_res, done_res, read_data,
                    input ready);
    modport sink (input valid, scl_level, sda_level, busy_res, done_res, read_data,
                  output ready);
endinterface
`default_nettype wire

### design/i2cee_in_stage.sv
// Input register stage that captures one tick transfer.
`default_nettype none
module i2cee_in_stage
    import i2cee_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    i2cee_req_if.sink i_req,
    input  wire logic i_advance,
    output t_req      o_item,
    output logic      o_valid
);

    logic r_valid;
    t_req r_item;
    logic w_accept;

    assign i_req.ready = !r_valid || i_advance;
    assign w_accept    = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.start_request <= i_req.start_request;
            r_item.operation     <= i_req.operation;
            r_item.word_address  <= i_req.word_address;
            r_item.write_data    <= i_req.write_data;
            r_item.sda_in        <= i_req.sda_in;
        end
    end

    assign o_item  = r_item;
    assign o_valid = r_valid;

endmodule
`default_nettype wire

### design/i2cee_sequencer.sv
// Bus sequencer: state registers and the per-tick next-state and output logic.
`default_nettype none
module i2cee_sequencer
    import i2cee_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_fire,
    input  wire t_req        i_item,
    input  wire logic [6:0]  i_dev_addr,
    input  wire logic [15:0] i_phase_ticks,
    output t_res             o_res,
    output logic [STEP_W-1:0] o_step
);

    logic [STEP_W-1:0] r_step, n_step;
    logic [3:0]        r_bit_pos, n_bit_pos;
    logic [1:0]        r_bit_phase, n_bit_phase;
    logic [15:0]       r_cnt, n_cnt;
    logic [7:0]        r_shift, n_shift;
    logic [16:0]       r_held, n_held;
    logic [7:0]        r_rx, n_rx;

    logic              w_is_byte;
    logic [15:0]       w_limit;
    logic [16:0]       w_cnt_inc;
    logic              w_done;
    logic [STEP_W-1:0] w_after;
    logic              w_scl, w_sda, w_busy;

    function automatic logic [7:0] byte_for(input logic [STEP_W-1:0] step,
                                            input logic [6:0] dev,
                                            input logic [16:0] held);
        logic [7:0] b;
        b = 8'd0;
        case (step)
            ST_DEVW:  b = {dev, RW_WRITE};
            ST_WADDR: b = held[15:8];
            ST_WDATA: b = held[7:0];
            ST_DEVR:  b = {dev, RW_READ};
            default:  b = 8'd0;
        endcase
        return b;
    endfunction

    assign w_is_byte = r_step inside {ST_DEVW, ST_WADDR, ST_WDATA, ST_DEVR, ST_RDATA};
    assign w_limit   = (i_phase_ticks == 16'd0) ? 16'd1 : i_phase_ticks;
    assign w_cnt_inc = {1'b0, r_cnt} + 17'd1;

    // Step that follows a finished byte (acknowledge clock done).
    always_comb begin
        case (r_step)
            ST_DEVW:  w_after = ST_WADDR;
            ST_WADDR: w_after = (r_held[16] == OP_READ) ? ST_START2 : ST_WDATA;
            ST_DEVR:  w_after = ST_RDATA;
            default:  w_after = ST_STOP;
        endcase
    end

    // Bus levels reflect the state at the start of the tick.
    always_comb begin
        w_scl  = 1'b1;
        w_sda  = 1'b1;
        w_busy = 1'b0;
        if (r_step == ST_START1 || r_step == ST_START2) begin
            w_scl  = (r_bit_phase == 2'd1) || (r_bit_phase == 2'd2);
            w_sda  = (r_bit_phase <= 2'd1);
            w_busy = 1'b1;
        end else if (r_step == ST_STOP) begin
            w_scl  = (r_bit_phase >= 2'd1);
            w_sda  = (r_bit_phase >= 2'd2);
            w_busy = 1'b1;
        end else if (w_is_byte) begin
            w_scl  = (r_bit_phase == 2'd1);
            w_sda  = (r_bit_pos < 4'd8 && r_step != ST_RDATA) ? r_shift[7] : 1'b1;
            w_busy = 1'b1;
        end
    end

    always_comb begin
        n_step      = r_step;
        n_bit_pos   = r_bit_pos;
        n_bit_phase = r_bit_phase;
        n_cnt       = r_cnt;
        n_shift     = r_shift;
        n_held      = r_held;
        n_rx        = r_rx;
        w_done      = 1'b0;
        if (r_step == ST_IDLE) begin
            if (i_item.start_request) begin
                n_held      = {i_item.operation, i_item.word_address, i_item.write_data};
                n_step      = ST_START1;
                n_bit_pos   = 4'd0;
                n_bit_phase = 2'd0;
                n_cnt       = 16'd0;
            end
        end else if (w_cnt_inc < {1'b0, w_limit}) begin
            n_cnt = w_cnt_inc[15:0];
        end else begin
            n_cnt = 16'd0;
            if (r_step == ST_START1 || r_step == ST_START2) begin
                if (r_bit_phase == 2'd3) begin
                    n_step      = (r_step == ST_START1) ? ST_DEVW : ST_DEVR;
                    n_bit_pos   = 4'd0;
                    n_bit_phase = 2'd0;
                    n_shift     = byte_for(n_step, i_dev_addr, r_held);
                end else begin
                    n_bit_phase = r_bit_phase + 2'd1;
                end
            end else if (r_step == ST_STOP) begin
                if (r_bit_phase >= 2'd2) begin
                    n_step      = ST_IDLE;
                    n_bit_pos   = 4'd0;
                    n_bit_phase = 2'd0;
                    w_done      = 1'b1;
                end else begin
                    n_bit_phase = r_bit_phase + 2'd1;
                end
            end else if (w_is_byte) begin
                // Read bits are sampled at the end of the SCL-high phase.
                if (r_bit_phase == 2'd1 && r_step == ST_RDATA && r_bit_pos < 4'd8) begin
                    n_shift = {r_shift[6:0], i_item.sda_in};
                end
                if (r_bit_phase < 2'd2) begin
                    n_bit_phase = r_bit_phase + 2'd1;
                end else begin
                    n_bit_phase = 2'd0;
                    if (r_bit_pos < 4'd8) begin
                        if (r_step != ST_RDATA) begin
                            n_shift = {r_shift[6:0], 1'b0};
                        end else if (r_bit_pos == 4'd7) begin
                            n_rx = r_shift;
                        end
                        n_bit_pos = r_bit_pos + 4'd1;
                    end else begin
                        n_step    = w_after;
                        n_bit_pos = 4'd0;
                        if (w_after != ST_STOP && w_after != ST_START2) begin
                            n_shift = byte_for(w_after, i_dev_addr, r_held);
                        end
                    end
                end
            end else begin
                n_step      = ST_IDLE;
                n_bit_pos   = 4'd0;
                n_bit_phase = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= ST_IDLE;
            r_bit_pos   <= 4'd0;
            r_bit_phase <= 2'd0;
            r_cnt       <= 16'd0;
            r_shift     <= 8'd0;
            r_held      <= 17'd0;
            r_rx        <= 8'd0;
        end else if (i_fire) begin
            r_step      <= n_step;
            r_bit_pos   <= n_bit_pos;
            r_bit_phase <= n_bit_phase;
            r_cnt       <= n_cnt;
            r_shift     <= n_shift;
            r_held      <= n_held;
            r_rx        <= n_rx;
        end
    end

    assign o_res.scl_level = w_scl;
    assign o_res.sda_level = w_sda;
    assign o_res.busy_res  = w_busy;
    assign o_res.done_res  = w_done;
    assign o_res.read_data = n_rx;
    assign o_step          = r_step;

endmodule
`default_nettype wire

### design/i2cee_out_stage.sv
// Result register stage that holds one tick result until it is taken.
`default_nettype none
module i2cee_out_stage
    import i2cee_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_load,
    input  wire t_res   i_res,
    i2cee_res_if.source o_res,
    output logic        o_free
);

    logic r_valid;
    t_res r_res;

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid     = r_valid;
    assign o_res.scl_level = r_res.scl_level;
    assign o_res.sda_level = r_res.sda_level;
    assign o_res.busy_res  = r_res.busy_res;
    assign o_res.done_res  = r_res.done_res;
    assign o_res.read_data = r_res.read_data;

endmodule
`default_nettype wire

### design/i2c_eeprom_byte_access_master_core.sv
// Top level of the I2C EEPROM single-byte access master.
// A tick transfer held in the input register passes through the sequencer logic into
// the result register whenever the result register is free or is being emptied.
// Throughput: one tick transfer per clock cycle under that same condition, set by the single
// pass from input register through the sequencer logic to the result register.
// Reset (i_rst_n low at a clock edge) empties both stages, puts the sequencer in idle
// and restores device_address to 80 and phase_ticks to 5.
`default_nettype none
`include "assert_macros.svh"
module i2c_eeprom_byte_access_master_core
    import i2cee_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    i2cee_req_if.sink                  i_req,
    i2cee_res_if.source                o_res,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // Configuration registers. A write takes effect at once, also in the middle
    // of an access, and the sequencer reads them directly.
    logic [6:0]  r_dev_addr;
    logic [15:0] r_phase_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr    <= DEVICE_ADDRESS_RST;
            r_phase_ticks <= PHASE_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEVICE_ADDRESS: r_dev_addr    <= i_cfg_wdata[6:0];
                CFG_PHASE_TICKS:    r_phase_ticks <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // The input stage holds one tick transfer. It moves into the sequencer and
    // the result register together, whenever the result register is free or is
    // being emptied in the same cycle, so the whole pipeline stalls as one.
    t_req              w_item;
    logic              w_in_valid;
    logic              w_out_free;
    logic              w_advance;
    t_res              w_res;
    logic [STEP_W-1:0] w_step;

    assign w_advance = w_in_valid && w_out_free;

    i2cee_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_advance (w_advance),
        .o_item    (w_item),
        .o_valid   (w_in_valid)
    );

    // The sequencer updates its bus state once per advanced tick and computes
    // the levels, status and read byte for that tick.
    i2cee_sequencer u_sequencer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_advance),
        .i_item        (w_item),
        .i_dev_addr    (r_dev_addr),
        .i_phase_ticks (r_phase_ticks),
        .o_res         (w_res),
        .o_step        (w_step)
    );

    i2cee_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_advance),
        .i_res   (w_res),
        .o_res   (o_res),
        .o_free  (w_out_free)
    );

    // A finishing tick is always the last tick of STOP, so it reports busy.
    `ASSERT_IMPLIES(a_done_is_busy, i_clk, i_rst_n, w_advance && w_res.done_res, w_res.busy_res)
    // After the finishing tick the sequencer is back in idle.
    `ASSERT_NEXT(a_done_to_idle, i_clk, i_rst_n, w_advance && w_res.done_res, w_step == ST_IDLE)
    // While the pipeline is stalled, the bus state must not move.
    `ASSERT_NEXT(a_stall_holds_step, i_clk, i_rst_n, !w_advance, $stable(w_step))

endmodule
`default_nettype wire
